FILE: design/plat_pkg.sv
// ----------------------------------------------------------------------------
// plat_pkg: shared types and constants
// table size, status codes, action codes and cell record types
// ----------------------------------------------------------------------------
package plat_pkg;

    localparam int TABLE_SLOTS  = 8;
    localparam int SLOT_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int MAX_RESULTS  = 8;
    localparam int OUT_SLOT_W   = 3;
    localparam logic [31:0] BROADCAST_ADDR = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ACT_ADD     = 2'd0,
        ACT_REMOVE  = 2'd1,
        ACT_RESTORE = 2'd2,
        ACT_LIST    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_INVALID   = 2'd3
    } status_t;

    // one table entry as held in a cell
    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] order;
        logic        pinned;
    } entry_t;

    // scan token handed from cell to cell
    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] found_slot;
        logic              have_free;
        logic [SLOT_W-1:0] free_slot;
        logic              have_old;
        logic [SLOT_W-1:0] old_slot;
        logic [31:0]       oldest;
    } scan_t;

    // command broadcast from the controller to every cell
    typedef struct packed {
        logic              write;
        logic              clear_all;
        logic              free;
        logic              newent;
        logic [SLOT_W-1:0] slot;
        logic [31:0]       addr;
        logic [31:0]       order;
        logic              pin;
    } cell_cmd_t;

endpackage

FILE: design/pinned_lru_address_table.sv
// ----------------------------------------------------------------------------
// pinned_lru_address_table: lru address table with pinned entries
// a row of slot cells scanned by a chained token, driven by a small sequencer
// ----------------------------------------------------------------------------
// usage:
//  - requests enter on s_axis (tdata = action, dest_addr, pin_flag) and
//    results leave on m_axis (tdata = status, slot_index, entry_ip,
//    entry_pin; tlast marks the final result of a request)
//  - one request is handled at a time; s_axis_tready is low while busy
//  - add / remove / restore: after acceptance the sequencer moves to S_EXEC,
//    where the search token ripples through the cell row; once the output
//    register is free, the table and the output register are loaded together
//    at the end of that S_EXEC cycle and the sequencer returns to S_IDLE for
//    the next request
//  - list: one slot walked per cycle while the output register is free,
//    then a closing S_OUT state; one result per valid slot, or a single
//    not-found result
//  - the result sits in an output register; a stalled receiver holds the
//    sequencer in place, nothing is dropped
//  - reset loads the broadcast entry pinned in slot 0 and the stamp
//    counter with one
// ----------------------------------------------------------------------------
module pinned_lru_address_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // action[1:0], dest_addr[33:2], pin_flag[34]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // status[1:0], slot_index[4:2], entry_ip[36:5], entry_pin[37]
    output logic        m_axis_tlast
);

    localparam int N  = plat_pkg::TABLE_SLOTS;
    localparam int SW = plat_pkg::SLOT_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_LIST = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // latched request
    plat_pkg::action_t act_reg;
    logic [31:0]       addr_reg;
    logic              pin_reg;
    logic [31:0]       counter_reg, counter_next;

    // list walk
    logic [SW:0]       idx_reg, idx_next;
    logic [3:0]        nout_reg, nout_next;

    // output register
    logic        ovalid_reg, ovalid_next;
    logic [1:0]  ostat_reg, ostat_next;
    logic [2:0]  oslot_reg, oslot_next;
    logic [31:0] oip_reg, oip_next;
    logic        opin_reg, opin_next;
    logic        olast_reg, olast_next;

    plat_pkg::scan_t   chain [N+1];
    plat_pkg::entry_t  ent   [N];
    plat_pkg::cell_cmd_t cmd;
    logic [31:0]       key;

    // valid slots, used to find the final listed entry
    logic [N-1:0]      valid_vec;
    logic [N-1:0]      above_vec;
    logic              more_valid;

    assign key = (act_reg == plat_pkg::ACT_RESTORE) ? plat_pkg::BROADCAST_ADDR : addr_reg;
    assign chain[0] = '0;

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            plat_pkg::entry_t rv;
            assign rv = (g == 0) ? '{addr: plat_pkg::BROADCAST_ADDR, order: 32'd1, pinned: 1'b1}
                                 : '0;
            assign valid_vec[g] = (ent[g].order != 32'd0);
            plat_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .my_slot  (SW'(g)),
                .rst_val  (rv),
                .key      (key),
                .cmd      (cmd),
                .scan_in  (chain[g]),
                .scan_out (chain[g+1]),
                .entry    (ent[g])
            );
        end
    endgenerate

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tlast  = olast_reg;
    assign m_axis_tdata  = {2'b00, opin_reg, oip_reg, oslot_reg, ostat_reg};

    logic              out_free;
    plat_pkg::scan_t   sc;
    plat_pkg::entry_t  cur;
    logic [SW-1:0]     idx_s;
    logic              is_last_idx;

    assign out_free    = !ovalid_reg || m_axis_tready;
    assign sc          = chain[N];
    assign idx_s       = idx_reg[SW-1:0];
    assign cur         = ent[idx_s];
    assign is_last_idx = (idx_reg == (SW+1)'(N-1));
    // any valid slot above the one being walked
    assign above_vec   = (valid_vec >> idx_s) >> 1;
    assign more_valid  = |above_vec;

    always_comb
    begin
        state_next   = state_reg;
        counter_next = counter_reg;
        idx_next     = idx_reg;
        nout_next    = nout_reg;
        ovalid_next  = ovalid_reg && !m_axis_tready;
        ostat_next   = ostat_reg;
        oslot_next   = oslot_reg;
        oip_next     = oip_reg;
        opin_next    = opin_reg;
        olast_next   = olast_reg;
        cmd          = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    idx_next  = '0;
                    nout_next = '0;
                    if (s_axis_tdata[1:0] == plat_pkg::ACT_LIST)
                        state_next = S_LIST;
                    else
                        state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    oip_next    = '0;
                    opin_next   = 1'b0;
                    olast_next  = 1'b1;
                    oslot_next  = '0;
                    ostat_next  = plat_pkg::ST_OK;
                    state_next  = S_IDLE;
                    case (act_reg)
                        plat_pkg::ACT_ADD:
                        begin
                            if (addr_reg == 32'd0)
                                ostat_next = plat_pkg::ST_INVALID;
                            else if (sc.found || sc.have_free || sc.have_old)
                            begin
                                counter_next = counter_reg + 32'd1;
                                cmd.write    = 1'b1;
                                cmd.order    = counter_next;
                                cmd.addr     = addr_reg;
                                cmd.pin      = pin_reg;
                                cmd.newent   = !sc.found;
                                cmd.slot     = sc.found ? sc.found_slot :
                                               sc.have_free ? sc.free_slot : sc.old_slot;
                                oslot_next   = 3'(cmd.slot);
                            end
                            else
                                ostat_next = plat_pkg::ST_FULL;
                        end
                        plat_pkg::ACT_REMOVE:
                        begin
                            if (sc.found)
                            begin
                                cmd.write  = 1'b1;
                                cmd.free   = 1'b1;
                                cmd.slot   = sc.found_slot;
                                oslot_next = 3'(sc.found_slot);
                            end
                            else
                                ostat_next = plat_pkg::ST_NOT_FOUND;
                        end
                        default:
                        begin
                            // restore: clear all, broadcast goes to slot 0
                            counter_next  = counter_reg + 32'd1;
                            cmd.clear_all = 1'b1;
                            cmd.write     = 1'b1;
                            cmd.newent    = 1'b1;
                            cmd.slot      = '0;
                            cmd.addr      = plat_pkg::BROADCAST_ADDR;
                            cmd.pin       = 1'b1;
                            cmd.order     = counter_next;
                        end
                    endcase
                end
            end
            S_LIST:
            begin
                if (out_free)
                begin
                    if (cur.order != 32'd0 && nout_reg < 4'(plat_pkg::MAX_RESULTS))
                    begin
                        ovalid_next = 1'b1;
                        ostat_next  = plat_pkg::ST_OK;
                        oslot_next  = 3'(idx_s);
                        oip_next    = cur.addr;
                        opin_next   = cur.pinned;
                        // last when no valid slot follows or the run is full
                        olast_next  = !more_valid ||
                                      (nout_reg == 4'(plat_pkg::MAX_RESULTS - 1));
                        nout_next   = nout_reg + 4'd1;
                    end
                    idx_next = idx_reg + 1'b1;
                    if (is_last_idx)
                        state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // close the run: emit an empty-table result if nothing was listed
                if (nout_reg == 4'd0)
                begin
                    if (out_free)
                    begin
                        ovalid_next = 1'b1;
                        ostat_next  = plat_pkg::ST_NOT_FOUND;
                        oslot_next  = '0;
                        oip_next    = '0;
                        opin_next   = 1'b0;
                        olast_next  = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
                else
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            counter_reg <= 32'd1;
            idx_reg     <= '0;
            nout_reg    <= '0;
            ovalid_reg  <= 1'b0;
            olast_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            counter_reg <= counter_next;
            idx_reg     <= idx_next;
            nout_reg    <= nout_next;
            ovalid_reg  <= ovalid_next;
            olast_reg   <= olast_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_axis_tvalid)
        begin
            act_reg  <= plat_pkg::action_t'(s_axis_tdata[1:0]);
            addr_reg <= s_axis_tdata[33:2];
            pin_reg  <= s_axis_tdata[34];
        end
        ostat_reg <= ostat_next;
        oslot_reg <= oslot_next;
        oip_reg   <= oip_next;
        opin_reg  <= opin_next;
    end

endmodule

FILE: design/plat_cell.sv
// ----------------------------------------------------------------------------
// plat_cell: one table slot
// holds one entry and folds it into the scan token passed to the next cell
// ----------------------------------------------------------------------------
module plat_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [plat_pkg::SLOT_W-1:0]     my_slot,
    input  plat_pkg::entry_t                rst_val,
    input  logic [31:0]                     key,
    input  plat_pkg::cell_cmd_t             cmd,
    input  plat_pkg::scan_t                 scan_in,
    output plat_pkg::scan_t                 scan_out,
    output plat_pkg::entry_t                entry
);

    plat_pkg::entry_t entry_reg;
    plat_pkg::entry_t entry_next;
    logic             used;

    assign used  = (entry_reg.order != 32'd0);
    assign entry = entry_reg;

    always_comb
    begin
        scan_out = scan_in;
        if (used && entry_reg.addr == key && !scan_in.found)
        begin
            scan_out.found      = 1'b1;
            scan_out.found_slot = my_slot;
        end
        if (!used && !scan_in.have_free)
        begin
            scan_out.have_free = 1'b1;
            scan_out.free_slot = my_slot;
        end
        // only slots before the first free one count for eviction
        if (used && !entry_reg.pinned && !scan_in.have_free &&
            (!scan_in.have_old || entry_reg.order < scan_in.oldest))
        begin
            scan_out.have_old = 1'b1;
            scan_out.old_slot = my_slot;
            scan_out.oldest   = entry_reg.order;
        end
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.clear_all)
        begin
            entry_next = '0;
        end
        if (cmd.write && cmd.slot == my_slot)
        begin
            if (cmd.free)
            begin
                entry_next.order  = 32'd0;
                entry_next.pinned = 1'b0;
            end
            else
            begin
                entry_next.order = cmd.order;
                if (cmd.newent)
                begin
                    entry_next.addr   = cmd.addr;
                    entry_next.pinned = cmd.pin;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_reg <= rst_val;
        else
            entry_reg <= entry_next;
    end

endmodule
